// ===== rtl/fwpe_pkg.sv =====
package fwpe_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TAG_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_EXTRACT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Running best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  idx;
  } scan_t;

  // Broadcast control from the controller to every cell.
  typedef struct packed {
    logic              load;
    logic              shift;
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  occ;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } cell_ctl_t;

endpackage

// ===== rtl/fwpe_cell.sv =====
module fwpe_cell
  import fwpe_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  cell_ctl_t         ctl,
  input  logic [TAG_W-1:0]  nbr_tag,
  input  logic [PRIO_W-1:0] nbr_prio,
  input  scan_t             scan_in,
  output logic [TAG_W-1:0]  tag_o,
  output logic [PRIO_W-1:0] prio_o,
  output scan_t             scan_o
);

  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  scan_t             scan_r, scan_nxt;
  logic              occupied;

  assign occupied = CNT_W'(cell_idx) < ctl.occ;

  // A push lands in the first free cell; a removal pulls every cell at or
  // behind the removed position one step toward the head.
  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctl.load && (CNT_W'(cell_idx) == ctl.occ)) begin
      tag_nxt  = ctl.tag;
      prio_nxt = ctl.prio;
    end else if (ctl.shift && (cell_idx >= ctl.sel)) begin
      tag_nxt  = nbr_tag;
      prio_nxt = nbr_prio;
    end
  end

  // Strict compare keeps the older entry on a tie.
  always_comb begin
    scan_nxt = scan_in;
    if (occupied && (!scan_in.found || (prio_r > scan_in.prio))) begin
      scan_nxt = '{found: 1'b1, prio: prio_r, tag: tag_r, idx: cell_idx};
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
    scan_r <= scan_nxt;
  end

  assign tag_o  = tag_r;
  assign prio_o = prio_r;
  assign scan_o = scan_r;

endmodule

// ===== rtl/fwpe_ctrl.sv =====
module fwpe_ctrl
  import fwpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [TAG_W-1:0]   in_item_tag,
  input  logic [PRIO_W-1:0]  in_item_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [TAG_W-1:0]   out_tag,
  output logic [PRIO_W-1:0]  out_priority,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_overflow,
  input  logic [TAG_W-1:0]   head_tag,
  input  logic [PRIO_W-1:0]  head_prio,
  input  scan_t              scan_best,
  output cell_ctl_t          cell_ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r;
  func_t              func_r;
  logic [TAG_W-1:0]   tag_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [IDX_W-1:0]   scan_cnt_r;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic               out_valid_r;
  logic               res_valid_r;
  logic [TAG_W-1:0]   res_tag_r;
  logic [PRIO_W-1:0]  res_prio_r;
  logic [COUNT_W-1:0] res_count_r;
  logic               res_ovf_r;

  logic               accept;
  logic               commit;
  logic               is_push;
  logic               is_remove;
  logic               full;
  logic               empty;
  logic               do_load;
  logic               do_shift;
  logic [TAG_W-1:0]   rem_tag;
  logic [PRIO_W-1:0]  rem_prio;
  logic [IDX_W-1:0]   rem_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign is_push   = (func_r == FUNC_PUSH);
  assign is_remove = (func_r == FUNC_POP) || (func_r == FUNC_EXTRACT);
  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign do_load   = commit && is_push && !full;
  assign do_shift  = commit && is_remove && !empty;

  always_comb begin
    if (func_r == FUNC_EXTRACT) begin
      rem_tag  = scan_best.tag;
      rem_prio = scan_best.prio;
      rem_idx  = scan_best.idx;
    end else begin
      rem_tag  = head_tag;
      rem_prio = head_prio;
      rem_idx  = '0;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_load) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (do_shift) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  assign cell_ctl = '{load: do_load, shift: do_shift, sel: rem_idx, occ: occ_r,
                      tag: tag_r, prio: prio_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      func_r      <= FUNC_NONE;
      tag_r       <= '0;
      prio_r      <= '0;
      scan_cnt_r  <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      res_tag_r   <= '0;
      res_prio_r  <= '0;
      res_count_r <= '0;
      res_ovf_r   <= 1'b0;
    end else begin
      // A new result keeps the output valid; otherwise a taken result frees it.
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r     <= func_t'(in_func);
            tag_r      <= in_item_tag;
            prio_r     <= in_item_priority;
            scan_cnt_r <= '0;
            if (func_t'(in_func) == FUNC_EXTRACT) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + IDX_W'(1);
          if (scan_cnt_r == IDX_W'(DEPTH - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            occ_r       <= occ_nxt;
            res_valid_r <= do_shift;
            res_tag_r   <= do_shift ? rem_tag : '0;
            res_prio_r  <= do_shift ? rem_prio : '0;
            res_count_r <= COUNT_W'(occ_nxt);
            res_ovf_r   <= is_push && full;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_valid_r;
  assign out_tag       = res_tag_r;
  assign out_priority  = res_prio_r;
  assign out_count     = res_count_r;
  assign out_overflow  = res_ovf_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy exceeds queue depth");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_shift |=> (occ_r == $past(occ_r) - CNT_W'(1)))
    else $error("removal did not decrement occupancy");

  a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && func_r == FUNC_EXTRACT && !empty)
      |-> (scan_best.found && (CNT_W'(scan_best.idx) < occ_r)))
    else $error("scan result not settled or outside occupied cells");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_valid_r && res_ovf_r))
    else $error("result both removed an entry and overflowed");

endmodule

// ===== rtl/fifo_with_priority_extract.sv =====
// Arrival-ordered queue of DEPTH (tag, priority) entries with three
// operations per request: push at the tail, pop the oldest entry, or
// extract the entry of highest priority (oldest wins on a tie).
//
// The input channel (in_valid/in_ready) carries in_func, in_item_tag and
// in_item_priority. Every request produces exactly one result on the
// output channel (out_valid/out_ready): out_valid_res, out_tag,
// out_priority, out_count (occupancy after the request) and out_overflow
// (a push that hit a full queue and was dropped).
//
// Storage is a row of cells. A removal shifts every younger cell one step
// toward the head at once; an extract first runs a registered
// compare chain through all cells, one cell per cycle.
// Push, pop and the unused code go from acceptance straight to S_DONE,
// where the result is registered; an extract passes through S_SCAN
// first while the compare chain runs. A new request is taken only once
// the controller is back in S_IDLE, so requests are handled one at a time.
// A waiting result does not block acceptance; a request that
// finishes while the result register is still full holds until the
// receiver takes it. Reset empties the queue and clears both channels.
module fifo_with_priority_extract
  import fwpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [TAG_W-1:0]   in_item_tag,
  input  logic [PRIO_W-1:0]  in_item_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [TAG_W-1:0]   out_tag,
  output logic [PRIO_W-1:0]  out_priority,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_overflow
);

  cell_ctl_t         cell_ctl;
  logic [TAG_W-1:0]  cell_tag  [DEPTH];
  logic [PRIO_W-1:0] cell_prio [DEPTH];
  scan_t             cell_scan [DEPTH];

  // The controller sequences each request and owns occupancy and the
  // result register.
  fwpe_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_item_tag      (in_item_tag),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_tag          (out_tag),
    .out_priority     (out_priority),
    .out_count        (out_count),
    .out_overflow     (out_overflow),
    .head_tag         (cell_tag[0]),
    .head_prio        (cell_prio[0]),
    .scan_best        (cell_scan[DEPTH-1]),
    .cell_ctl         (cell_ctl)
  );

  // Cell 0 is the head. Cells at or behind a removed entry take their
  // younger neighbor's entry; each cell passes the best so far toward the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_W-1:0]  nbr_tag;
    logic [PRIO_W-1:0] nbr_prio;
    scan_t             scan_in;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr_tag  = '0;
      assign nbr_prio = '0;
    end else begin : g_mid
      assign nbr_tag  = cell_tag[i+1];
      assign nbr_prio = cell_prio[i+1];
    end

    if (i == 0) begin : g_first
      assign scan_in = '0;
    end else begin : g_rest
      assign scan_in = cell_scan[i-1];
    end

    fwpe_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (cell_ctl),
      .nbr_tag  (nbr_tag),
      .nbr_prio (nbr_prio),
      .scan_in  (scan_in),
      .tag_o    (cell_tag[i]),
      .prio_o   (cell_prio[i]),
      .scan_o   (cell_scan[i])
    );
  end

endmodule

// ===== tb/sv/fwpe_checker_pkg.sv =====
package fwpe_checker_pkg;

  import fwpe_pkg::*;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } held_entry_t;

  typedef struct {
    logic               valid_res;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } removal_t;

  // Mirrors the queue contents and keeps the results still owed by the block.
  class removal_tracker;
    held_entry_t held[$];
    removal_t    owed[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      // Printing is capped so that a badly broken block cannot flood the log.
      if (mismatches < 100) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    function void note_request(func_t op, logic [TAG_W-1:0] tag,
                               logic [PRIO_W-1:0] prio);
      removal_t r;
      int       best;
      r = '{default: 0};
      case (op)
        FUNC_PUSH: begin
          if (held.size() >= DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            held.push_back('{tag: tag, prio: prio});
          end
        end
        FUNC_POP, FUNC_EXTRACT: begin
          if (held.size() > 0) begin
            best = 0;
            // Strict compare keeps the oldest entry on a priority tie.
            if (op == FUNC_EXTRACT) begin
              for (int i = 1; i < held.size(); i++) begin
                if (held[i].prio > held[best].prio) best = i;
              end
            end
            r.valid_res = 1'b1;
            r.tag       = held[best].tag;
            r.prio      = held[best].prio;
            held.delete(best);
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(held.size());
      owed.push_back(r);
    endfunction

    task compare_field(string name, longint got, longint want);
      if (got != want) begin
        report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
    endtask

    task check_result(logic valid_res, logic [TAG_W-1:0] tag,
                      logic [PRIO_W-1:0] prio, logic [COUNT_W-1:0] count,
                      logic overflow);
      removal_t w;
      if (owed.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        w = owed.pop_front();
        compare_field("valid_res", valid_res, w.valid_res);
        compare_field("tag", tag, w.tag);
        compare_field("priority", prio, w.prio);
        compare_field("count", count, w.count);
        compare_field("overflow", overflow, w.overflow);
      end
    endtask

    task flag_unanswered();
      while (owed.size() > 0) begin
        void'(owed.pop_front());
        report("request never produced a result");
      end
    endtask
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import fwpe_pkg::*;
  import fwpe_checker_pkg::*;

  // The slowest legal run covers about 825 requests, extracts that walk the
  // whole compare chain, sender gaps, receiver stalls and one long receiver
  // hold-off. The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_COUNT = 800;
  localparam int HOLD_CYCLES  = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [TAG_W-1:0]   in_item_tag;
  logic [PRIO_W-1:0]  in_item_priority;
  logic               out_valid;
  logic               out_ready;
  logic               out_valid_res;
  logic [TAG_W-1:0]   out_tag;
  logic [PRIO_W-1:0]  out_priority;
  logic [COUNT_W-1:0] out_count;
  logic               out_overflow;

  removal_tracker tracker;

  // While set, neither side inserts random idle cycles.
  bit no_idle = 1'b0;
  // Remaining cycles of a forced receiver hold-off; counted down below.
  int hold_off = 0;
  int cycle_count = 0;

  fifo_with_priority_extract DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_item_tag      (in_item_tag),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_tag          (out_tag),
    .out_priority     (out_priority),
    .out_count        (out_count),
    .out_overflow     (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Both channels are observed at the rising edge. Every accepted request
  // updates the predicted queue and queues up the result it must produce;
  // every accepted result is checked against the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.note_request(func_t'(in_func), in_item_tag, in_item_priority);
      end
      if (out_valid && out_ready) begin
        tracker.check_result(out_valid_res, out_tag, out_priority, out_count,
                             out_overflow);
      end
    end
  end

  // Result receiver. It normally drops ready in about one cycle in five.
  // A pending hold-off keeps ready low for a long stretch, which lets the
  // block fill its result path and push back on the request side.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off = hold_off - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  // Offers one request and returns at the falling edge after it is taken.
  // It is entered at a falling edge. A random gap lowers valid first; the
  // raise then happens at a later edge, so valid is never lowered and
  // raised in the same time step. Without a gap, valid simply stays high
  // and the new payload replaces the one just accepted.
  task automatic send_request(func_t op, logic [TAG_W-1:0] tag,
                              logic [PRIO_W-1:0] prio);
    if (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= op;
    in_item_tag      <= tag;
    in_item_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random payload for a request of the given kind. Half of the
  // priorities come from four coarse levels so that ties are frequent,
  // which exercises the oldest-wins rule of an extract.
  task automatic send_random(func_t op);
    logic [PRIO_W-1:0] prio;
    if ($urandom_range(1) == 1) begin
      prio = PRIO_W'($urandom_range(255));
    end else begin
      prio = PRIO_W'($urandom_range(3) << 6);
    end
    send_request(op, TAG_W'($urandom_range(16'hFFFF)), prio);
  endtask

  initial begin
    logic [PRIO_W-1:0] fill_prio [16];
    int                push_pct;
    int                pick;
    func_t             op;

    tracker          = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_PUSH;
    in_item_tag      = '0;
    in_item_priority = '0;
    out_ready        = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. First the empty queue: pop, extract and the unused
    // code must all report nothing removed and a count of zero.
    send_request(FUNC_POP, 16'hFFFF, 8'hFF);
    send_request(FUNC_EXTRACT, 16'hFFFF, 8'hFF);
    send_request(FUNC_NONE, 16'hFFFF, 8'hFF);

    // Fill the queue to the brim. Tags run from all zeros to all ones and
    // the priorities include zero and three entries at the maximum, so the
    // extracts below must pick the oldest of the tied entries.
    fill_prio = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd255, 8'd1, 8'd64, 8'd254,
                  8'd128, 8'd3, 8'd200, 8'd255, 8'd9, 8'd100, 8'd2, 8'd50};
    for (int i = 0; i < DEPTH; i++) begin
      send_request(FUNC_PUSH, TAG_W'(i * 16'h1111), fill_prio[i % 16]);
    end

    // A push onto the full queue is dropped with overflow set, and the
    // unused code on a full queue only reports the count.
    send_request(FUNC_PUSH, 16'hABCD, 8'hFF);
    send_request(FUNC_NONE, 16'h0000, 8'h00);

    // Two extracts take the tied maximum entries in arrival order, then a
    // pop takes the head.
    send_request(FUNC_EXTRACT, 16'h0000, 8'h00);
    send_request(FUNC_EXTRACT, 16'h0000, 8'h00);
    send_request(FUNC_POP, 16'h0000, 8'h00);

    // Random part. The share of pushes changes every 50 requests so that
    // the queue swings between empty and full many times over the run.
    push_pct = 50;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if (n % 50 == 0) begin
        pick = $urandom_range(2);
        push_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
      end
      // A long stretch with no idle cycles on either side.
      no_idle = (n >= 300 && n < 500);
      // Once, the receiver stops taking results for a long while; the
      // sender keeps offering requests until the block stalls its input.
      if (n == 600) begin
        hold_off = HOLD_CYCLES;
      end
      if ($urandom_range(99) < push_pct) begin
        op = FUNC_PUSH;
      end else begin
        pick = $urandom_range(9);
        op = (pick == 0) ? FUNC_NONE : (pick < 5) ? FUNC_POP : FUNC_EXTRACT;
      end
      send_random(op);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain: wait for every owed result, then allow for a late extra one.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    tracker.flag_unanswered();

    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
